@@ src/bitplane_framebuffer_draw_top_assert.svh @@
// Assertion macros for the bitplane framebuffer draw block
`ifndef BITPLANE_FRAMEBUFFER_DRAW_TOP_ASSERT_SVH
`define BITPLANE_FRAMEBUFFER_DRAW_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BFD_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BFD_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define BFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/bfd_pkg.sv @@
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and codes of the bitplane framebuffer draw block.
// ----------------------------------------------------------------------------
`default_nettype none
package bfd_pkg;
	localparam logic [2:0] KIND_PIXEL = 3'd0;
	localparam logic [2:0] KIND_HLINE = 3'd1;
	localparam logic [2:0] KIND_VLINE = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	localparam logic [1:0] INK_BLACK   = 2'd0;
	localparam logic [1:0] INK_WHITE   = 2'd1;
	localparam logic [1:0] INK_COLOUR  = 2'd2;
	localparam logic [1:0] INK_INVERSE = 2'd3;

	localparam logic [2:0] REG_ROTATION = 3'd0;
	localparam logic [2:0] REG_TRICOL   = 3'd1;
	localparam logic [2:0] REG_PWIDTH   = 3'd2;
	localparam logic [2:0] REG_PHEIGHT  = 3'd3;
	localparam logic [2:0] REG_VWIDTH   = 3'd4;

	// Operation handed from front to back: walk bytes of one physical row
	// (horizontal), or one byte column over rows (vertical), or read/clear.
	localparam logic [1:0] OP_ROW   = 2'd0;
	localparam logic [1:0] OP_COL   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  ink;
		logic [10:0] x0;     // first physical x (column ops: the column)
		logic [10:0] x_end;  // one past last x (row ops)
		logic [10:0] y0;     // first row
		logic [10:0] y_end;  // one past last row (column ops)
		logic [12:0] index;  // read address
		logic        oob;    // read beyond the plane
	} cmd_t;
endpackage
`default_nettype wire

@@ src/bfd_ram.sv @@
// ----------------------------------------------------------------------------
// bfd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read first at the address (old data on a write), read registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

@@ src/bfd_front.sv @@
// ----------------------------------------------------------------------------
// bfd_front
// Accepts requests, maps rotation, clips and emits physical commands.
// ----------------------------------------------------------------------------
`default_nettype none
module bfd_front import bfd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic signed [10:0] pos_x,
	input  wire logic signed [10:0] pos_y,
	input  wire logic signed [10:0] span,
	input  wire logic [1:0]  ink,
	input  wire logic [12:0] byte_index,
	input  wire logic [1:0]  rotation,
	input  wire logic [9:0]  plane_width,
	input  wire logic [9:0]  plane_height,
	input  wire logic [9:0]  visible_width,
	input  wire logic [13:0] plane_lim,
	output logic             cmd_valid,
	input  wire logic        cmd_ready,
	output cmd_t             cmd
);
	// Signed 13-bit arithmetic covers all sums of 11-bit values and 10-bit sizes
	logic signed [12:0] x, y, n, pw, ph, lw, lh, vw;
	logic signed [12:0] ax, ay, an;   // physical start and length
	logic               is_row, go;
	logic signed [12:0] s0, e0, lo_lim, hi_lim;
	logic               issue;
	cmd_t               c;

	assign x  = 13'(pos_x);
	assign y  = 13'(pos_y);
	assign n  = 13'(span);
	assign pw = {3'b0, plane_width[9:3], 3'b0};
	assign ph = {3'b0, plane_height};
	assign vw = {3'b0, visible_width};
	assign lw = rotation[0] ? ph : vw;
	assign lh = rotation[0] ? vw : ph;

	// Map logical request to a physical row or column segment
	always_comb begin
		ax = x; ay = y; an = n; is_row = 1'b1; go = 1'b0;
		case (kind)
			KIND_PIXEL: begin
				an = 13'sd1;
				go = (x >= 0) && (x < lw) && (y >= 0) && (y < lh);
				case (rotation)
					2'd0: begin ax = x; ay = y; end
					2'd1: begin ax = pw - y - 13'sd1; ay = x; end
					2'd2: begin ax = pw - x - 13'sd1; ay = ph - y - 13'sd1; end
					default: begin ax = y; ay = ph - x - 13'sd1; end
				endcase
			end
			KIND_HLINE: begin
				go = n > 0;
				case (rotation)
					2'd0: begin ax = x; ay = y; end
					2'd1: begin ax = pw - y - 13'sd1; ay = x; is_row = 1'b0; end
					2'd2: begin ax = pw - x - n; ay = ph - y - 13'sd1; end
					default: begin ax = y; ay = ph - x - n; is_row = 1'b0; end
				endcase
			end
			KIND_VLINE: begin
				go = n > 0;
				case (rotation)
					2'd0: begin ax = x; ay = y; is_row = 1'b0; end
					2'd1: begin ax = pw - y - n; ay = x; end
					2'd2: begin ax = pw - x - 13'sd1; ay = ph - y - n; is_row = 1'b0; end
					default: begin ax = y; ay = ph - x - 13'sd1; end
				endcase
			end
			default: ;
		endcase
	end

	// Clip the segment along its axis
	always_comb begin
		lo_lim = is_row ? pw : ph;
		s0 = is_row ? ax : ay;
		e0 = s0 + an;
		if (s0 < 0) s0 = '0;
		if (e0 > lo_lim) e0 = lo_lim;
		hi_lim = is_row ? ph : pw;
		c = '0;
		c.ink = ink;
		c.index = byte_index;
		c.oob = {1'b0, byte_index} >= plane_lim;
		c.op = is_row ? OP_ROW : OP_COL;
		if (is_row) begin
			c.x0 = s0[10:0]; c.x_end = e0[10:0]; c.y0 = ay[10:0]; c.y_end = ay[10:0];
		end else begin
			c.x0 = ax[10:0]; c.x_end = ax[10:0]; c.y0 = s0[10:0]; c.y_end = e0[10:0];
		end
		issue = 1'b0;
		case (kind)
			KIND_PIXEL, KIND_HLINE, KIND_VLINE: begin
				issue = go && (e0 > s0) &&
					(is_row ? (ay >= 0 && ay < hi_lim) : (ax >= 0 && ax < hi_lim));
			end
			KIND_CLEAR: begin c.op = OP_CLEAR; issue = 1'b1; end
			KIND_READ:  begin c.op = OP_READ;  issue = 1'b1; end
			default: ;
		endcase
	end

	// Register the command; drop requests that draw nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (in_ready) begin
			cmd_valid <= in_valid && issue;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) cmd <= c;
	end

	assign in_ready = !cmd_valid || cmd_ready;
endmodule
`default_nettype wire

@@ src/bfd_queue.sv @@
// ----------------------------------------------------------------------------
// bfd_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module bfd_queue import bfd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  cmd_t      wr_cmd,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output cmd_t      rd_cmd
);
	cmd_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign push = wr_valid && wr_ready;
	assign pop  = rd_valid && rd_ready;
	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_cmd = slot_q[rp_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= wr_cmd;
	end
endmodule
`default_nettype wire

@@ src/bfd_back.sv @@
// ----------------------------------------------------------------------------
// bfd_back
// Carries out commands as byte read-modify-write over both planes, and byte reads.
// ----------------------------------------------------------------------------
`default_nettype none
module bfd_back import bfd_pkg::*; #(
	parameter int PLANE_BYTES = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	input  wire logic        tricolour_mode,
	input  wire logic [9:0]  plane_width,
	input  wire logic [16:0] clear_bytes,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       mono_byte,
	output logic [7:0]       colour_byte
);
	localparam int AW = $clog2(PLANE_BYTES);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_WR    = 3'd2;
	localparam logic [2:0] ST_RESET = 3'd3;
	localparam logic [2:0] ST_RDOUT = 3'd4;

	logic [2:0]  st_q;
	cmd_t        c_q;
	logic [10:0] cx_q, cy_q;
	logic [16:0] addr_q, clr_q;
	logic [16:0] row_base;
	logic [16:0] step_addr;
	logic [7:0]  mask, mono_rd, col_rd, mono_wd, col_wd;
	logic        we, last, in_range;
	logic [AW-1:0] ram_addr;
	logic [2:0]  lo;
	logic [10:0] rem;

	// Row base: y times bytes per row for the current step
	assign row_base = 17'(cy_q) * 17'(plane_width[9:3]);
	assign step_addr = row_base + 17'(cx_q[10:3]);

	// Byte mask for the current step
	always_comb begin
		lo = cx_q[2:0];
		rem = c_q.x_end - {cx_q[10:3], 3'b0};
		mask = 8'hFF;
		if (c_q.op == OP_COL) begin
			mask = 8'h80 >> c_q.x0[2:0];
		end else if (c_q.op == OP_ROW) begin
			mask = 8'hFF >> lo;
			if (rem < 11'd8) mask = mask & ~(8'hFF >> rem[2:0]);
		end
	end

	// New byte values under the plane rules
	always_comb begin
		mono_wd = mono_rd;
		col_wd  = col_rd;
		case (c_q.ink)
			INK_BLACK: begin
				mono_wd = mono_rd & ~mask;
				if (tricolour_mode) col_wd = col_rd | mask;
			end
			INK_WHITE: begin
				mono_wd = mono_rd | mask;
				if (tricolour_mode) col_wd = col_rd | mask;
			end
			INK_COLOUR: begin
				if (tricolour_mode) begin
					col_wd = col_rd & ~mask;
					mono_wd = mono_rd | mask;
				end
			end
			default: begin
				mono_wd = mono_rd ^ mask;
				if (tricolour_mode && c_q.op != OP_CLEAR) col_wd = col_rd | mask;
			end
		endcase
	end

	assign in_range = (st_q == ST_RESET) || (addr_q < 17'(PLANE_BYTES));
	assign we = (st_q == ST_RESET) || ((st_q == ST_WR) && in_range);
	assign ram_addr = (st_q == ST_RESET) ? clr_q[AW-1:0] :
		(st_q == ST_IDLE) ? AW'(cmd.index) :
		((st_q == ST_RD) && (c_q.op != OP_CLEAR)) ? step_addr[AW-1:0] :
		addr_q[AW-1:0];

	always_comb begin
		last = 1'b1;
		case (c_q.op)
			OP_ROW:   last = ({cx_q[10:3], 3'b0} + 11'd8) >= c_q.x_end;
			OP_COL:   last = (cy_q + 11'd1) >= c_q.y_end;
			OP_CLEAR: last = (addr_q + 17'd1) >= clear_bytes;
			default:  last = 1'b1;
		endcase
	end

	bfd_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_mono (
		.clk(clk), .we(we), .addr(ram_addr),
		.wdata((st_q == ST_RESET) ? 8'h00 : mono_wd), .rdata(mono_rd));
	bfd_ram #(.WIDTH(8), .DEPTH(PLANE_BYTES)) u_col (
		.clk(clk), .we(we), .addr(ram_addr),
		.wdata((st_q == ST_RESET) ? 8'h00 : col_wd), .rdata(col_rd));

	assign cmd_ready = (st_q == ST_IDLE) && !out_valid;

	// Sequence: clear sweep after reset, then read / write per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
			clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (st_q)
				ST_RESET: begin
					clr_q <= clr_q + 17'd1;
					if (clr_q == 17'(PLANE_BYTES - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						if (cmd.op == OP_READ) st_q <= ST_RDOUT;
						else if (cmd.op == OP_CLEAR && clear_bytes == 17'd0) st_q <= ST_IDLE;
						else st_q <= ST_RD;
					end
				end
				ST_RDOUT: begin
					out_valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				ST_RD: st_q <= ST_WR;
				ST_WR: st_q <= last ? ST_IDLE : ST_RD;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the command and walk the byte position
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid && cmd_ready) begin
			c_q <= cmd;
			cx_q <= cmd.x0;
			cy_q <= cmd.y0;
			addr_q <= '0;
		end else if (st_q == ST_RD) begin
			if (c_q.op != OP_CLEAR)
				addr_q <= step_addr;
		end else if (st_q == ST_WR) begin
			if (c_q.op == OP_ROW) cx_q <= {cx_q[10:3], 3'b0} + 11'd8;
			if (c_q.op == OP_COL) cy_q <= cy_q + 11'd1;
			if (c_q.op == OP_CLEAR) addr_q <= addr_q + 17'd1;
		end
		if (st_q == ST_RDOUT) begin
			mono_byte   <= c_q.oob ? 8'h00 : mono_rd;
			colour_byte <= c_q.oob ? 8'h00 : col_rd;
		end
	end
endmodule
`default_nettype wire

@@ src/bitplane_framebuffer_draw_top.sv @@
// ----------------------------------------------------------------------------
// bitplane_framebuffer_draw_top
// Bitplane framebuffer draw engine.
// Requests (pixel, horizontal/vertical line, clear, byte read) enter on the
// in_valid/in_ready channel. A front stage maps rotation and clips, then
// posts a physical command into a two-deep queue; the back stage
// executes it as read-modify-write of one byte at a time on the mono and
// colour planes, which are single-port RAMs. The back stage takes a command
// while idle, then reads and writes each byte touched in turn; a clear
// touches clear_bytes bytes. A read request passes the front command
// register and the queue, then the back stage enters its read-out state and
// registers out_valid. Requests that draw nothing are dropped at the front.
// After reset both planes are swept to zero, one byte a cycle, during
// which no command is executed; configuration writes over the APB port
// are taken at any time.
// A stalled receiver holds the read beat in its output register; the back
// stage waits, the queue fills and then in_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitplane_framebuffer_draw_top_assert.svh"
module bitplane_framebuffer_draw_top import bfd_pkg::*; #(
	parameter int PLANE_BYTES = 8192
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic signed [10:0] pos_x,
	input  wire logic signed [10:0] pos_y,
	input  wire logic signed [10:0] span,
	input  wire logic [1:0]  ink,
	input  wire logic [12:0] byte_index,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       mono_byte,
	output logic [7:0]       colour_byte,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [1:0] rotation_q;
	logic       tricol_q;
	logic [9:0] pwidth_q, pheight_q, vwidth_q;
	logic [16:0] clear_bytes;
	logic [16:0] total;
	logic [13:0] plane_lim;
	logic       f_valid, f_ready, b_valid, b_ready;
	cmd_t       f_cmd, b_cmd;
	logic       wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= 2'd0; tricol_q <= 1'b0;
			pwidth_q <= 10'd128; pheight_q <= 10'd296; vwidth_q <= 10'd128;
		end else if (wr) begin
			case (paddr[4:2])
				REG_ROTATION: rotation_q <= pwdata[1:0];
				REG_TRICOL:   tricol_q <= pwdata[0];
				REG_PWIDTH:   pwidth_q <= pwdata[9:0];
				REG_PHEIGHT:  pheight_q <= pwdata[9:0];
				REG_VWIDTH:   vwidth_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_ROTATION: prdata = {30'd0, rotation_q};
			REG_TRICOL:   prdata = {31'd0, tricol_q};
			REG_PWIDTH:   prdata = {22'd0, pwidth_q};
			REG_PHEIGHT:  prdata = {22'd0, pheight_q};
			REG_VWIDTH:   prdata = {22'd0, vwidth_q};
			default:      prdata = '0;
		endcase
	end

	// Clear length, capped at the plane size
	assign total = 17'(pwidth_q[9:3]) * 17'(pheight_q);
	assign clear_bytes = (total > 17'(PLANE_BYTES)) ? 17'(PLANE_BYTES) : total;
	assign plane_lim = (PLANE_BYTES > 8192) ? 14'd8192 : 14'(PLANE_BYTES);

	bfd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .pos_x(pos_x), .pos_y(pos_y), .span(span), .ink(ink),
		.byte_index(byte_index), .rotation(rotation_q), .plane_width(pwidth_q),
		.plane_height(pheight_q), .visible_width(vwidth_q), .plane_lim(plane_lim),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));

	bfd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_cmd(f_cmd), .rd_valid(b_valid), .rd_ready(b_ready), .rd_cmd(b_cmd));

	bfd_back #(.PLANE_BYTES(PLANE_BYTES)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(b_valid), .cmd_ready(b_ready),
		.cmd(b_cmd), .tricolour_mode(tricol_q), .plane_width(pwidth_q),
		.clear_bytes(clear_bytes), .out_valid(out_valid), .out_ready(out_ready),
		.mono_byte(mono_byte), .colour_byte(colour_byte));

	// A held result beat keeps its payload
	`BFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(mono_byte), "result beat changed while stalled")
	// Back takes no command while a result beat waits
	`BFD_ASSERT_IMPL(a_no_take, clk, arst_n, out_valid |-> !b_ready, "command taken with result pending")
	// A front command stalled by a full queue stays valid until taken
	`BFD_ASSERT_IMPL(a_front, clk, arst_n, (f_valid && !f_ready) |=> f_valid, "front command lost")
endmodule
`default_nettype wire
